[rtl/pgph_pkg.sv]
// Shared types, codes and helpers for the packet header parser.
package pgph_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TAG_W     = 6;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned LCNT_W    = 3;
  localparam int unsigned ROLE_W    = 2;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [PHASE_W-1:0] PH_HDR       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NEW_FIRST = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NEW_TWO   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_NEW_FOUR  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OLD_LEN   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BODY      = 3'd5;
  localparam logic [PHASE_W-1:0] PH_HUNT      = 3'd6;

  localparam logic [ROLE_W-1:0] ROLE_HDR     = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_BODY    = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_DISCARD = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_CTB    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_PARTIAL   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_INDET     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_END_HDR   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_END_BODY  = 3'd5;

  localparam logic [TAG_W-1:0] TAG_COMPRESSED = 6'd8;
  localparam logic [TAG_W-1:0] TAG_SYM_ENC    = 6'd9;
  localparam logic [TAG_W-1:0] TAG_LITERAL    = 6'd11;
  localparam logic [TAG_W-1:0] TAG_SYM_ENC_IP = 6'd18;

  localparam logic [BYTE_W-1:0] LEN_TWO_MIN  = 8'd192;
  localparam logic [BYTE_W-1:0] LEN_PART_MIN = 8'd224;
  localparam logic [BYTE_W-1:0] LEN_FIVE     = 8'd255;
  localparam logic [LCNT_W-1:0] LEN_FIVE_CNT = 3'd4;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TAG_W-1:0]   tag;
    logic               fmt_new;
    logic [LEN_W-1:0]   accum;
    logic [LCNT_W-1:0]  len_left;
    logic [LEN_W-1:0]   body_left;
    logic               to_end;
  } pgph_state_t;

  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic              to_end;
    logic [LEN_W-1:0]  body_len;
    logic              fmt_new;
    logic [TAG_W-1:0]  tag;
    logic              body_last;
    logic              hdr_done;
    logic [ROLE_W-1:0] role;
    logic [BYTE_W-1:0] data;
  } pgph_result_t;

  function automatic logic tag_partial_ok(input logic [TAG_W-1:0] t);
    return t inside {TAG_COMPRESSED, TAG_SYM_ENC, TAG_LITERAL, TAG_SYM_ENC_IP};
  endfunction

  function automatic logic tag_indet_ok(input logic [TAG_W-1:0] t);
    return t inside {TAG_COMPRESSED, TAG_SYM_ENC, TAG_LITERAL};
  endfunction

endpackage

[rtl/pgph_fsm.sv]
// Header framing state machine: state registers and per-byte next-state logic.
module pgph_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [pgph_pkg::BYTE_W-1:0]   byte_in,
  input  logic                          last_in,
  output pgph_pkg::pgph_result_t        res
);
  import pgph_pkg::*;

  pgph_state_t        st_r, st_nxt;
  logic               discard, more, fin, fail, fin_end;
  logic [LEN_W-1:0]   fin_len;
  logic [ERR_W-1:0]   fail_code;
  logic [LEN_W-1:0]   acc_sh, bl_dec;
  logic [LCNT_W-1:0]  lcnt_dec;
  logic [TAG_W-1:0]   tag_old;

  always_comb begin
    st_nxt    = st_r;
    discard   = 1'b0;
    more      = 1'b0;
    fin       = 1'b0;
    fin_len   = '0;
    fin_end   = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    acc_sh    = {st_r.accum[LEN_W-BYTE_W-1:0], byte_in};
    bl_dec    = (st_r.body_left != '0) ? st_r.body_left - 1'b1 : '0;
    lcnt_dec  = (st_r.len_left != '0) ? st_r.len_left - 1'b1 : '0;
    tag_old   = {2'b00, byte_in[5:2]};
    res           = '0;
    res.data      = byte_in;
    res.role      = ROLE_HDR;
    res.err       = ERR_NONE;

    case (st_r.phase)
      PH_NEW_FIRST: begin
        if (byte_in < LEN_TWO_MIN) begin
          fin     = 1'b1;
          fin_len = {{(LEN_W-BYTE_W){1'b0}}, byte_in};
        end else if (byte_in < LEN_PART_MIN) begin
          st_nxt.accum = {{(LEN_W-5){1'b0}}, byte_in[4:0]};
          st_nxt.phase = PH_NEW_TWO;
          more         = 1'b1;
        end else if (byte_in == LEN_FIVE) begin
          st_nxt.accum    = '0;
          st_nxt.len_left = LEN_FIVE_CNT;
          st_nxt.phase    = PH_NEW_FOUR;
          more            = 1'b1;
        end else if (tag_partial_ok(st_r.tag)) begin
          fin     = 1'b1;
          fin_len = {{(LEN_W-1){1'b0}}, 1'b1} << byte_in[4:0];
          fin_end = 1'b1;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_PARTIAL;
        end
      end
      PH_NEW_TWO: begin
        fin     = 1'b1;
        fin_len = acc_sh + {{(LEN_W-BYTE_W){1'b0}}, LEN_TWO_MIN};
      end
      PH_NEW_FOUR, PH_OLD_LEN: begin
        st_nxt.accum    = acc_sh;
        st_nxt.len_left = lcnt_dec;
        if (lcnt_dec == '0) begin
          fin     = 1'b1;
          fin_len = acc_sh;
        end else begin
          more = 1'b1;
        end
      end
      PH_BODY: begin
        res.role     = ROLE_BODY;
        res.body_len = st_r.accum;
        res.to_end   = st_r.to_end;
        if (st_r.to_end) begin
          if (last_in) begin
            res.body_last = 1'b1;
            st_nxt.phase  = PH_HDR;
          end
        end else begin
          st_nxt.body_left = bl_dec;
          if (bl_dec == '0) begin
            res.body_last = 1'b1;
            st_nxt.phase  = PH_HDR;
          end else if (last_in) begin
            res.body_last = 1'b1;
            res.err       = ERR_END_BODY;
            st_nxt.phase  = PH_HDR;
          end
        end
      end
      default: begin
        if (!byte_in[7]) begin
          discard = 1'b1;
          if (st_r.phase == PH_HUNT) begin
            st_nxt.phase = last_in ? PH_HDR : PH_HUNT;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_NO_CTB;
          end
        end else begin
          st_nxt.fmt_new = byte_in[6];
          if (byte_in[6]) begin
            st_nxt.tag   = byte_in[5:0];
            st_nxt.phase = PH_NEW_FIRST;
            more         = 1'b1;
          end else begin
            st_nxt.tag = tag_old;
            if (byte_in[1:0] == 2'b11) begin
              if (tag_indet_ok(tag_old)) begin
                fin     = 1'b1;
                fin_end = 1'b1;
              end else begin
                fail      = 1'b1;
                fail_code = ERR_INDET;
              end
            end else begin
              st_nxt.accum    = '0;
              st_nxt.len_left = LCNT_W'(3'd1 << byte_in[1:0]);
              st_nxt.phase    = PH_OLD_LEN;
              more            = 1'b1;
            end
          end
        end
      end
    endcase

    if (fin) begin
      res.hdr_done     = 1'b1;
      res.body_len     = fin_len;
      res.to_end       = fin_end;
      st_nxt.accum     = fin_len;
      st_nxt.body_left = fin_len;
      st_nxt.to_end    = fin_end;
      if (!fin_end && fin_len == '0) begin
        st_nxt.phase = PH_HDR;
      end else if (last_in) begin
        if (!fin_end) res.err = ERR_END_BODY;
        st_nxt.phase = PH_HDR;
      end else begin
        st_nxt.phase = PH_BODY;
      end
    end

    if (fail) begin
      res.err      = fail_code;
      st_nxt.phase = last_in ? PH_HDR : PH_HUNT;
    end

    if (more && last_in) begin
      res.err      = ERR_END_HDR;
      st_nxt.phase = PH_HDR;
    end

    if (discard) begin
      res.role    = ROLE_DISCARD;
      res.tag     = '0;
      res.fmt_new = 1'b0;
    end else begin
      res.tag     = st_nxt.tag;
      res.fmt_new = st_nxt.fmt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/pgp_packet_header_parser_unit.sv]
// A byte is held in the input register, framed, and its result held in the output register that drives out_*.
// Throughput: one byte per cycle while the output is not stalled; input and output registers
// let a byte be taken while a finished result still waits, if the input register is empty.
// The framing state is one register set updated once per byte.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to expecting a header byte.
// Top level of the packet header parser.
module pgp_packet_header_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pgph_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] in_byte
  input  logic                                in_tlast,   // stream_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] out_byte, [13:8] packet_tag, [14] new_format, [46:15] body_length,
  // [47] to_stream_end, [50:48] error_code, [55:51] zero
  output logic [pgph_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [pgph_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [1:0] byte_role, [2] header_done
  output logic                                out_tlast   // body_last
);
  import pgph_pkg::*;

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_last_r;
  logic               out_valid_r;
  pgph_result_t       res_r;
  pgph_result_t       res;
  logic               adv, fire;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  pgph_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[BYTE_W-1:0];
      in_last_r <= in_tlast;
    end
    if (fire) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, res_r.err, res_r.to_end, res_r.body_len,
                       res_r.fmt_new, res_r.tag, res_r.data};
  assign out_tuser  = {res_r.hdr_done, res_r.role};
  assign out_tlast  = res_r.body_last;

endmodule

[rtl/pgph_checker.sv]
// Port-level checks for the packet header parser, bound to the top level.
module pgph_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pgph_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [pgph_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input logic                              out_tlast
);
  import pgph_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ROLE_DISCARD |->
      out_tdata[46:8] == '0 && !out_tuser[2] && !out_tlast)
    else $error("discarded byte carries packet fields");

  a_last_is_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1:0] == ROLE_BODY && !out_tuser[2])
    else $error("body end flagged on a non-body byte");

endmodule

bind pgp_packet_header_parser_unit pgph_checker u_pgph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/pgph_frame_checker.sv]
// Checker for the packet header parser: predicts each framed byte and compares it with the output.
`timescale 1ns / 100ps

module pgph_frame_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [pgph_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] in_byte
  input  logic                             in_tlast,   // stream_last
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_byte, [13:8] packet_tag, [14] new_format, [46:15] body_length,
  // [47] to_stream_end, [50:48] error_code, [55:51] zero
  input  logic [pgph_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [pgph_pkg::OUT_TUSER_W-1:0] out_tuser,  // [1:0] byte_role, [2] header_done
  input  logic                             out_tlast,  // body_last
  output int                               fail_count,
  output int                               pending
);
  import pgph_pkg::*;

  localparam logic [1:0] OLD_LEN_INDET = 2'd3;

  logic [PHASE_W-1:0] phase_r;
  logic [TAG_W-1:0]   tag_r;
  logic               fmt_r;
  logic [LEN_W-1:0]   accum_r;
  logic [LCNT_W-1:0]  octets_r;
  logic [LEN_W-1:0]   remain_r;
  logic               to_end_r;

  pgph_result_t framed_q[$];
  int           fails;

  initial begin
    fails = 0;
  end

  task automatic close_header(input logic [LEN_W-1:0] len, input logic te, input logic last,
                              inout pgph_result_t r);
    r.hdr_done = 1'b1;
    r.body_len = len;
    r.to_end   = te;
    accum_r    = len;
    remain_r   = len;
    to_end_r   = te;
    if (!te && len == '0) begin
      phase_r = PH_HDR;
    end else if (last) begin
      if (!te) r.err = ERR_END_BODY;
      phase_r = PH_HDR;
    end else begin
      phase_r = PH_BODY;
    end
  endtask

  task automatic abandon(input logic [ERR_W-1:0] code, input logic last,
                         inout pgph_result_t r);
    r.err   = code;
    phase_r = last ? PH_HDR : PH_HUNT;
  endtask

  task automatic frame_byte(input logic [BYTE_W-1:0] b, input logic last,
                            output pgph_result_t r);
    logic discard;
    logic more;
    discard = 1'b0;
    more    = 1'b0;
    r       = '0;
    case (phase_r)
      PH_NEW_FIRST: begin
        if (b < LEN_TWO_MIN) begin
          close_header({24'd0, b}, 1'b0, last, r);
        end else if (b < LEN_PART_MIN) begin
          accum_r = {24'd0, b - LEN_TWO_MIN};
          phase_r = PH_NEW_TWO;
          more    = 1'b1;
        end else if (b == LEN_FIVE) begin
          accum_r  = '0;
          octets_r = LEN_FIVE_CNT;
          phase_r  = PH_NEW_FOUR;
          more     = 1'b1;
        end else if (tag_r == TAG_COMPRESSED || tag_r == TAG_SYM_ENC ||
                     tag_r == TAG_LITERAL || tag_r == TAG_SYM_ENC_IP) begin
          close_header(32'd1 << b[4:0], 1'b1, last, r);
        end else begin
          abandon(ERR_PARTIAL, last, r);
        end
      end
      PH_NEW_TWO: begin
        close_header({accum_r[23:0], b} + {24'd0, LEN_TWO_MIN}, 1'b0, last, r);
      end
      PH_NEW_FOUR, PH_OLD_LEN: begin
        accum_r = {accum_r[23:0], b};
        if (octets_r != '0) octets_r = octets_r - 1'b1;
        if (octets_r == '0) close_header(accum_r, 1'b0, last, r);
        else more = 1'b1;
      end
      PH_BODY: begin
        r.role     = ROLE_BODY;
        r.body_len = accum_r;
        r.to_end   = to_end_r;
        if (to_end_r) begin
          if (last) begin
            r.body_last = 1'b1;
            phase_r     = PH_HDR;
          end
        end else begin
          if (remain_r != '0) remain_r = remain_r - 1'b1;
          if (remain_r == '0) begin
            r.body_last = 1'b1;
            phase_r     = PH_HDR;
          end else if (last) begin
            r.body_last = 1'b1;
            r.err       = ERR_END_BODY;
            phase_r     = PH_HDR;
          end
        end
      end
      default: begin
        if (!b[7]) begin
          discard = 1'b1;
          if (phase_r == PH_HUNT) phase_r = last ? PH_HDR : PH_HUNT;
          else abandon(ERR_NO_CTB, last, r);
        end else begin
          fmt_r = b[6];
          if (fmt_r) begin
            tag_r   = b[5:0];
            phase_r = PH_NEW_FIRST;
            more    = 1'b1;
          end else begin
            tag_r = {2'b00, b[5:2]};
            if (b[1:0] == OLD_LEN_INDET) begin
              if (tag_r == TAG_COMPRESSED || tag_r == TAG_SYM_ENC || tag_r == TAG_LITERAL)
                close_header('0, 1'b1, last, r);
              else
                abandon(ERR_INDET, last, r);
            end else begin
              accum_r  = '0;
              octets_r = 3'd1 << b[1:0];
              phase_r  = PH_OLD_LEN;
              more     = 1'b1;
            end
          end
        end
      end
    endcase
    if (more && last) begin
      r.err   = ERR_END_HDR;
      phase_r = PH_HDR;
    end
    r.data    = b;
    r.role    = discard ? ROLE_DISCARD : r.role;
    r.tag     = discard ? '0 : tag_r;
    r.fmt_new = discard ? 1'b0 : fmt_r;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    pgph_result_t want;
    pgph_result_t nxt;
    if (!rst_n) begin
      phase_r  = PH_HDR;
      tag_r    = '0;
      fmt_r    = 1'b0;
      accum_r  = '0;
      octets_r = '0;
      remain_r = '0;
      to_end_r = 1'b0;
      framed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (framed_q.size() == 0) begin
          $error("unexpected result request, data %0h", out_tdata);
          fails++;
        end else begin
          want = framed_q.pop_front();
          check_field("out_byte", 32'(want.data), 32'(out_tdata[7:0]));
          check_field("packet_tag", 32'(want.tag), 32'(out_tdata[13:8]));
          check_field("new_format", 32'(want.fmt_new), 32'(out_tdata[14]));
          check_field("body_length", want.body_len, out_tdata[46:15]);
          check_field("to_stream_end", 32'(want.to_end), 32'(out_tdata[47]));
          check_field("error_code", 32'(want.err), 32'(out_tdata[50:48]));
          check_field("tdata_pad", '0, 32'(out_tdata[55:51]));
          check_field("byte_role", 32'(want.role), 32'(out_tuser[1:0]));
          check_field("header_done", 32'(want.hdr_done), 32'(out_tuser[2]));
          check_field("body_last", 32'(want.body_last), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        frame_byte(in_tdata[7:0], in_tlast, nxt);
        framed_q.insert(framed_q.size(), nxt);
      end
    end
    pending    <= framed_q.size();
    fail_count <= fails;
  end

endmodule

[tb/tb_top.sv]
// Top of the packet header parser testbench: clock, reset, byte streams and verdict.
`timescale 1ns / 100ps

module tb_top;
  import pgph_pkg::*;

  localparam int          RANDOM_ITEMS = 1450;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          BODY_CAP     = 200;
  localparam logic [7:0]  CTB_NEW      = 8'hC0;
  localparam logic [7:0]  CTB_OLD      = 8'h80;
  localparam logic [1:0]  LT_ONE       = 2'd0;
  localparam logic [1:0]  LT_TWO       = 2'd1;
  localparam logic [1:0]  LT_FOUR      = 2'd2;
  localparam logic [1:0]  LT_INDET     = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] in_byte
  logic                   in_tlast = 1'b0; // stream_last
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] out_byte, [13:8] packet_tag, [14] new_format, [46:15] body_length,
  // [47] to_stream_end, [50:48] error_code, [55:51] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;       // [1:0] byte_role, [2] header_done
  logic                   out_tlast;       // body_last

  int         fail_count;
  int         pending;
  int         sent = 0;
  bit         steady = 1'b0;
  bit         hold_off = 1'b0;
  logic [7:0] stream_q[$];

  always #5 clk = ~clk;

  pgp_packet_header_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  pgph_frame_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [5:0] pick_tag();
    case ($urandom_range(0, 9))
      0: return TAG_COMPRESSED;
      1: return TAG_SYM_ENC;
      2: return TAG_LITERAL;
      3: return TAG_SYM_ENC_IP;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [31:0] wide_len(input logic [31:0] mask);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 12);
    if (r < 85) return $urandom_range(0, BODY_CAP);
    return $urandom & mask;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    stream_q = {stream_q, b};
  endfunction

  // a body longer than the cap is cut short, and the stream ends inside it
  function automatic bit add_body(input logic [31:0] len, input bit to_end);
    int n;
    if (to_end || len > BODY_CAP) begin
      n = $urandom_range(0, 20);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
      return 1'b1;
    end
    repeat (len) put_byte(8'($urandom_range(0, 255)));
    return 1'b0;
  endfunction

  function automatic bit add_packet();
    logic [5:0]  tag;
    logic [31:0] len;
    logic [12:0] off;
    tag = pick_tag();
    case ($urandom_range(0, 9))
      0, 1: begin
        len = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 191);
        put_byte(CTB_NEW | {2'b00, tag});
        put_byte(len[7:0]);
        return add_body(len, 1'b0);
      end
      2: begin
        off = ($urandom_range(0, 9) < 7) ? 13'($urandom_range(0, 8))
                                         : 13'($urandom_range(0, 8191));
        len = 32'd192 + {19'd0, off};
        put_byte(CTB_NEW | {2'b00, tag});
        put_byte(LEN_TWO_MIN + {3'b000, off[12:8]});
        put_byte(off[7:0]);
        return add_body(len, 1'b0);
      end
      3: begin
        len = wide_len(32'hFFFF_FFFF);
        put_byte(CTB_NEW | {2'b00, tag});
        put_byte(LEN_FIVE);
        put_byte(len[31:24]);
        put_byte(len[23:16]);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        return add_body(len, 1'b0);
      end
      4: begin
        put_byte(CTB_NEW | {2'b00, tag});
        put_byte(8'($urandom_range(LEN_PART_MIN, LEN_FIVE - 1)));
        return add_body('0, 1'b1);
      end
      5, 6: begin
        len = wide_len(32'h0000_00FF);
        put_byte(CTB_OLD | {2'b00, tag[3:0], LT_ONE});
        put_byte(len[7:0]);
        return add_body(len, 1'b0);
      end
      7: begin
        len = wide_len(32'h0000_FFFF);
        put_byte(CTB_OLD | {2'b00, tag[3:0], LT_TWO});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        return add_body(len, 1'b0);
      end
      8: begin
        len = wide_len(32'hFFFF_FFFF);
        put_byte(CTB_OLD | {2'b00, tag[3:0], LT_FOUR});
        put_byte(len[31:24]);
        put_byte(len[23:16]);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        return add_body(len, 1'b0);
      end
      default: begin
        put_byte(CTB_OLD | {2'b00, tag[3:0], LT_INDET});
        return add_body('0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // mostly well-formed packets; some streams get leading noise, a cut or trailing junk
  task automatic send_stream(input int min_bytes);
    int mode;
    int npk;
    int cut;
    mode = $urandom_range(0, 9);
    if (mode == 0) repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    npk = $urandom_range(1, 4);
    while (npk > 0 || stream_q.size() < min_bytes) begin
      npk--;
      if (add_packet()) break;
    end
    if (mode == 1 && stream_q.size() > 1) begin
      cut = $urandom_range(1, stream_q.size() - 1);
      while (stream_q.size() > cut) void'(stream_q.pop_back());
    end
    if (mode == 2) repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    while (stream_q.size() < min_bytes) put_byte(8'($urandom_range(0, 255)));
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  initial begin
    logic [8:0] directed[$];
    bit         pressed;
    pressed  = 1'b0;
    // {stream_last, byte}
    directed = '{9'h03C, 9'h012, 9'h0FF, 9'h000, 9'h0BD, 9'h000, 9'h001, 9'h0AA,
                 9'h0C8, 9'h0FE, 9'h1FF, 9'h0C1, 9'h0E0, 9'h087, 9'h0AF, 9'h180,
                 9'h1C2, 9'h0C2, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h101,
                 9'h088, 9'h103};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    while (sent < directed.size() + RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 7) == 0);
      if (!pressed && sent > RANDOM_ITEMS / 2) begin
        pressed  = 1'b1;
        steady   = 1'b1;
        hold_off = 1'b1;
        send_stream(40);
      end else begin
        send_stream(1);
      end
    end
    in_tvalid <= 1'b0;
    // pending is a registered copy of the checker's queue size, so it lags the checker
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int gap;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
